// ===== rtl/tks_pkg.sv =====
// shared types and constants for the top-k selector
`timescale 1ns / 1ps

package tks_pkg;

  localparam int SCORE_W = 32;
  localparam int CLASS_W = 16;
  localparam int K_CFG_W = 4;

  localparam logic [K_CFG_W-1:0]        K_RESET     = 4'd5;
  localparam logic signed [SCORE_W-1:0] SCORE_EMPTY = 32'sh8000_0000;
  localparam logic [CLASS_W-1:0]        CLASS_EMPTY = 16'hFFFF;

  // one input request
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      last_item;
  } tks_in_t;

  // one ranked result
  typedef struct packed {
    logic signed [SCORE_W-1:0] ranked_score;
    logic [CLASS_W-1:0]        ranked_class;
    logic                      filled;
    logic                      last_rank;
  } tks_out_t;

  // one rank as handed from the store to the output buffer
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [CLASS_W-1:0]        cls;
    logic                      filled;
  } tks_entry_t;

  // output buffer status seen by the request stage
  typedef struct packed {
    logic busy;
    logic can_load;
  } tks_drain_stat_t;

endpackage

// ===== rtl/tks_insert.sv =====
// ranked store with parallel compare-and-shift insertion
`timescale 1ns / 1ps

module tks_insert
  import tks_pkg::*;
#(
  parameter int K_MAX     = 8,
  parameter int MAX_ITEMS = 65536,
  parameter int KW        = $clog2(K_MAX + 1),
  parameter int CNT_W     = $clog2(MAX_ITEMS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          commit,
  input  tks_in_t       item,
  input  logic [KW-1:0] kk,
  output tks_entry_t    snap [K_MAX]
);

  localparam int IW = (K_MAX > 1) ? $clog2(K_MAX) : 1;

  logic signed [SCORE_W-1:0] score_r [K_MAX];
  logic [CLASS_W-1:0]        class_r [K_MAX];
  logic [KW-1:0]             held_r;
  logic [CNT_W-1:0]          cnt_r;

  logic signed [SCORE_W-1:0] score_nxt [K_MAX];
  logic [CLASS_W-1:0]        class_nxt [K_MAX];
  logic signed [SCORE_W-1:0] above_s   [K_MAX];
  logic [CLASS_W-1:0]        above_c   [K_MAX];
  logic [K_MAX-1:0]          ge;
  logic [K_MAX-1:0]          above_ge;
  logic [KW-1:0]             held_t;
  logic [KW-1:0]             held_new;
  logic [KW-1:0]             km1;
  logic [CNT_W+CLASS_W-1:0]  cnt_ext;
  logic [CLASS_W-1:0]        cls_in;
  logic                      active;
  logic                      insert_ok;

  // entries ranked below a shrunken k are dropped first
  assign held_t  = (held_r > kk) ? kk : held_r;
  assign active  = (cnt_r < CNT_W'(MAX_ITEMS));
  assign cnt_ext = {{CLASS_W{1'b0}}, cnt_r};
  assign cls_in  = cnt_ext[CLASS_W-1:0];
  assign km1     = kk - KW'(1);

  always_comb begin
    for (int i = 0; i < K_MAX; i++) begin
      ge[i] = (KW'(i) < held_t) && (score_r[i] >= item.score);
    end
    above_ge[0] = 1'b1;
    above_s[0]  = item.score;
    above_c[0]  = cls_in;
    for (int i = 1; i < K_MAX; i++) begin
      above_ge[i] = ge[i-1];
      above_s[i]  = score_r[i-1];
      above_c[i]  = class_r[i-1];
    end
  end

  // held entries are sorted, so ge is a prefix: the new score lands after it
  assign insert_ok = active && !ge[km1[IW-1:0]];

  always_comb begin
    for (int i = 0; i < K_MAX; i++) begin
      if (!insert_ok || ge[i]) begin
        score_nxt[i] = score_r[i];
        class_nxt[i] = class_r[i];
      end else if (above_ge[i]) begin
        score_nxt[i] = item.score;
        class_nxt[i] = cls_in;
      end else begin
        score_nxt[i] = above_s[i];
        class_nxt[i] = above_c[i];
      end
    end
  end

  assign held_new = (insert_ok && (held_t < kk)) ? held_t + KW'(1) : held_t;

  always_comb begin
    for (int i = 0; i < K_MAX; i++) begin
      if (KW'(i) < held_new) begin
        snap[i] = '{score: score_nxt[i], cls: class_nxt[i], filled: 1'b1};
      end else begin
        snap[i] = '{score: SCORE_EMPTY, cls: CLASS_EMPTY, filled: 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      cnt_r  <= '0;
    end else if (commit) begin
      if (item.last_item) begin
        held_r <= '0;
        cnt_r  <= '0;
      end else begin
        held_r <= held_new;
        if (active) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      for (int i = 0; i < K_MAX; i++) begin
        score_r[i] <= score_nxt[i];
        class_r[i] <= class_nxt[i];
      end
    end
  end

endmodule

// ===== rtl/tks_drain.sv =====
// output buffer that shifts out a loaded ranked set one result at a time
`timescale 1ns / 1ps

module tks_drain
  import tks_pkg::*;
#(
  parameter int K_MAX = 8,
  parameter int KW    = $clog2(K_MAX + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  logic [KW-1:0]   kk,
  input  tks_entry_t      snap [K_MAX],
  output logic            out_valid,
  input  logic            out_stall,
  output tks_out_t        out_data,
  output tks_drain_stat_t stat
);

  tks_entry_t    buf_r [K_MAX];
  logic [KW-1:0] rem_r;
  logic          out_accept;

  assign out_valid  = (rem_r != '0);
  assign out_accept = out_valid && !out_stall;

  assign out_data = '{
    ranked_score: buf_r[0].score,
    ranked_class: buf_r[0].cls,
    filled:       buf_r[0].filled,
    last_rank:    (rem_r == KW'(1))
  };

  // a new set may enter as the final rank of the current one leaves
  assign stat.busy     = out_valid;
  assign stat.can_load = (rem_r == '0) || ((rem_r == KW'(1)) && !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (load) begin
      rem_r <= kk;
    end else if (out_accept) begin
      rem_r <= rem_r - KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < K_MAX; i++) begin
        buf_r[i] <= snap[i];
      end
    end else if (out_accept) begin
      for (int i = 0; i < K_MAX - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
    end
  end

endmodule

// ===== rtl/top_k_selector.sv =====
// top level of the streaming top-k selector
`timescale 1ns / 1ps

// Streaming top-k selector. Scores arrive one per request, numbered from 0;
// the k best (k from cfg_wr_data, 0 read as 1, above K_MAX read as K_MAX) are
// kept in descending order, ties going to the earlier class. A request with
// last_item set makes the block emit k ranked results, one per cycle while
// out_stall is low, then start a new stream. Each request is registered,
// then parallel compare-and-shift over the K_MAX slots updates the store,
// so one score is taken every cycle unless a last request waits. The ranked
// set moves into an output buffer, so scores of the next stream keep flowing
// while it drains; a further last request waits until that buffer is
// emptying its final rank, so streams shorter than k items are paced by the
// drain. A last request is registered, then its set loads into the buffer.

module top_k_selector
  import tks_pkg::*;
#(
  parameter int K_MAX     = 8,
  parameter int MAX_ITEMS = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tks_in_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tks_out_t           out_data,
  input  logic               cfg_wr_en,
  input  logic [K_CFG_W-1:0] cfg_wr_data
);

  localparam int KW = $clog2(K_MAX + 1);

  logic [K_CFG_W-1:0] k_cfg_r;
  logic               pend_valid_r;
  tks_in_t            pend_item_r;
  logic [KW-1:0]      kk;
  logic               advance;
  logic               load;
  logic               in_accept;
  tks_entry_t         snap [K_MAX];
  tks_drain_stat_t    stat;

  always_comb begin
    if (k_cfg_r == '0) begin
      kk = KW'(1);
    end else if (32'(k_cfg_r) > K_MAX) begin
      kk = KW'(K_MAX);
    end else begin
      kk = KW'(k_cfg_r);
    end
  end

  // a last request needs room in the output buffer
  assign advance   = pend_valid_r && (!pend_item_r.last_item || stat.can_load);
  assign load      = advance && pend_item_r.last_item;
  assign in_stall  = pend_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_cfg_r <= K_RESET;
    end else if (cfg_wr_en) begin
      k_cfg_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (in_accept) begin
      pend_valid_r <= 1'b1;
    end else if (advance) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pend_item_r <= in_data;
    end
  end

  tks_insert #(
    .K_MAX     (K_MAX),
    .MAX_ITEMS (MAX_ITEMS)
  ) u_insert (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (advance),
    .item   (pend_item_r),
    .kk     (kk),
    .snap   (snap)
  );

  tks_drain #(
    .K_MAX (K_MAX)
  ) u_drain (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .kk        (kk),
    .snap      (snap),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .stat      (stat)
  );

endmodule
